@@ sv/sic_pkg.sv @@
// ----------------------------------------------------------------------------
// sic_pkg
// Types, result codes and saturation helper shared by the segment
// intersection classifier modules.
// ----------------------------------------------------------------------------
package sic_pkg;

  typedef struct packed {
    logic signed [31:0] first_start_x;
    logic signed [31:0] first_start_y;
    logic signed [31:0] first_start_z;
    logic signed [31:0] first_end_x;
    logic signed [31:0] first_end_y;
    logic signed [31:0] first_end_z;
    logic signed [31:0] second_start_x;
    logic signed [31:0] second_start_y;
    logic signed [31:0] second_start_z;
    logic signed [31:0] second_end_x;
    logic signed [31:0] second_end_y;
    logic signed [31:0] second_end_z;
  } sic_in_t;

  typedef struct packed {
    logic [2:0]         hit_class;
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
    logic signed [31:0] cross_z;
  } sic_out_t;

  localparam logic [2:0] CLASS_PARALLEL = 3'd0;
  localparam logic [2:0] CLASS_NEITHER  = 3'd1;
  localparam logic [2:0] CLASS_FIRST    = 3'd2;
  localparam logic [2:0] CLASS_SECOND   = 3'd3;
  localparam logic [2:0] CLASS_BOTH     = 3'd4;

  localparam logic REG_PARALLEL_TOL = 1'b0;
  localparam logic REG_ON_SEG_TOL   = 1'b1;

  localparam int NUM_W = 100;
  localparam int FD_W  = 67;

  localparam int QB = 33;
  localparam int QW = QB + 2;
  typedef logic signed [QW-1:0] quo_t;
  localparam quo_t QUO_LIMIT = 35'sd8589934592;

  localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
  localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ sv/segment_intersection_classifier_core.sv @@
// ----------------------------------------------------------------------------
// segment_intersection_classifier_core
// Intersects two segments in the XY plane, classifies the hit and
// interpolates Z.
// ----------------------------------------------------------------------------
// A request carries two segments as start and end points in signed Q16.16.
// It is taken on request_valid and request_ready; the result, with the hit
// class and the saturated X, Y and Z, leaves on result_valid and result_ready.
// One request can be taken every cycle while the pipeline is not held. A request
// passes the setup stages, three 34-stage dividers (X, Y and Z, one quotient
// bit per stage after the input stage) and the product stages between them.
// When the result register is full and not taken, the whole pipeline holds
// and request_ready drops in the same cycle; nothing is lost or repeated.
// Reset empties the pipeline and loads the tolerances with 1 and 429.
// The tolerances are written through cfg_write, cfg_index and cfg_data and
// must only change while no request is in flight.
// ----------------------------------------------------------------------------
module segment_intersection_classifier_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_ready,
  input  sic_pkg::sic_in_t  request,
  output logic              result_valid,
  input  logic              result_ready,
  output sic_pkg::sic_out_t result,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data
);
  import sic_pkg::*;

  typedef struct packed {
    logic    parallel;
    sic_in_t pts;
  } xside_t;

  typedef struct packed {
    logic               parallel;
    sic_in_t            pts;
    logic signed [31:0] x;
    logic signed [31:0] sy;
  } yside_t;

  typedef struct packed {
    logic               parallel;
    sic_in_t            pts;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } oside_t;

  typedef struct packed {
    logic               parallel;
    logic [2:0]         cls;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] sz;
  } zside_t;

  function automatic logic signed [32:0] diff33(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    return 33'(a) - 33'(b);
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  logic        en;
  logic [31:0] par_tol, on_tol;

  logic                     f_valid, f_par;
  logic signed [NUM_W-1:0]  f_num;
  logic signed [FD_W-1:0]   f_den;
  sic_in_t                  f_side;

  logic   xd_valid;
  quo_t   xd_quo;
  xside_t xd_in, xd_out;

  logic signed [31:0] x_sat;
  logic               y_sel1;
  logic               y1_valid;
  xside_t             y1_side;
  logic signed [31:0] y1_x, y1_sy;
  logic signed [32:0] y1_dy, y1_dx, y1_xm;

  logic               y2_valid;
  yside_t             y2_side;
  logic signed [65:0] y2_prod;
  logic signed [32:0] y2_dx;

  logic   yd_valid;
  quo_t   yd_quo;
  yside_t yd_out;

  logic signed [31:0] y_sat;
  logic signed [32:0] sdx1, sdy1, sdx2, sdy2;
  logic               ux1, ux2;
  logic               o1_valid;
  oside_t             o1_side;
  logic signed [32:0] o1_a1, o1_b1, o1_a2, o1_b2;

  logic               o2_valid;
  oside_t             o2_side;
  logic signed [65:0] o2_p1, o2_p2;

  logic               on1, on2, zs1, uy;
  logic signed [65:0] on_lim;
  logic signed [31:0] zsx, zsy, zsz, zex, zey, zez;
  logic signed [32:0] zdx, zdy;
  logic               o3_valid;
  zside_t             o3_side;
  logic signed [32:0] o3_dz, o3_f, o3_den;

  logic               o4_valid;
  zside_t             o4_side;
  logic signed [65:0] o4_prod;
  logic signed [32:0] o4_den;

  logic   zd_valid;
  quo_t   zd_quo;
  zside_t zd_out;
  logic signed [31:0] z_sat;

  assign en            = !result_valid || result_ready;
  assign request_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      par_tol <= 32'd1;
      on_tol  <= 32'd429;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PARALLEL_TOL: par_tol <= cfg_data;
        REG_ON_SEG_TOL:   on_tol  <= cfg_data;
        default:          par_tol <= par_tol;
      endcase
    end
  end

  sic_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (request_valid),
    .request      (request),
    .parallel_tol (par_tol),
    .out_valid    (f_valid),
    .num          (f_num),
    .den          (f_den),
    .parallel     (f_par),
    .side         (f_side)
  );

  assign xd_in = '{parallel: f_par, pts: f_side};

  sic_div #(.NW(NUM_W), .DW(FD_W), .PW($bits(xside_t))) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .num       (f_num),
    .den       (f_den),
    .side_in   (xd_in),
    .out_valid (xd_valid),
    .quo       (xd_quo),
    .side_out  (xd_out)
  );

  // Y follows the line whose X extent is larger.
  assign x_sat  = sat32(36'(xd_quo));
  assign y_sel1 = mag33(diff33(xd_out.pts.first_end_x, xd_out.pts.first_start_x))
                > mag33(diff33(xd_out.pts.second_end_x, xd_out.pts.second_start_x));

  always_ff @(posedge clk) begin
    if (en) begin
      y1_side <= xd_out;
      y1_x    <= x_sat;
      if (y_sel1) begin
        y1_dx <= diff33(xd_out.pts.first_end_x, xd_out.pts.first_start_x);
        y1_dy <= diff33(xd_out.pts.first_end_y, xd_out.pts.first_start_y);
        y1_xm <= diff33(x_sat, xd_out.pts.first_start_x);
        y1_sy <= xd_out.pts.first_start_y;
      end else begin
        y1_dx <= diff33(xd_out.pts.second_end_x, xd_out.pts.second_start_x);
        y1_dy <= diff33(xd_out.pts.second_end_y, xd_out.pts.second_start_y);
        y1_xm <= diff33(x_sat, xd_out.pts.second_start_x);
        y1_sy <= xd_out.pts.second_start_y;
      end

      y2_side <= '{parallel: y1_side.parallel, pts: y1_side.pts, x: y1_x, sy: y1_sy};
      y2_prod <= y1_dy * y1_xm;
      y2_dx   <= y1_dx;
    end
  end

  sic_div #(.NW(66), .DW(33), .PW($bits(yside_t))) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (y2_valid),
    .num       (y2_prod),
    .den       (y2_dx),
    .side_in   (y2_side),
    .out_valid (yd_valid),
    .quo       (yd_quo),
    .side_out  (yd_out)
  );

  assign y_sat = sat32(36'(yd_quo) + 36'(yd_out.sy));
  assign sdx1  = diff33(yd_out.pts.first_end_x, yd_out.pts.first_start_x);
  assign sdy1  = diff33(yd_out.pts.first_end_y, yd_out.pts.first_start_y);
  assign sdx2  = diff33(yd_out.pts.second_end_x, yd_out.pts.second_start_x);
  assign sdy2  = diff33(yd_out.pts.second_end_y, yd_out.pts.second_start_y);
  assign ux1   = mag33(sdx1) > mag33(sdy1);
  assign ux2   = mag33(sdx2) > mag33(sdy2);

  always_ff @(posedge clk) begin
    if (en) begin
      o1_side <= '{parallel: yd_out.parallel, pts: yd_out.pts, x: yd_out.x, y: y_sat};
      o1_a1 <= ux1 ? diff33(yd_out.x, yd_out.pts.first_start_x)
                   : diff33(y_sat, yd_out.pts.first_start_y);
      o1_b1 <= ux1 ? diff33(yd_out.x, yd_out.pts.first_end_x)
                   : diff33(y_sat, yd_out.pts.first_end_y);
      o1_a2 <= ux2 ? diff33(yd_out.x, yd_out.pts.second_start_x)
                   : diff33(y_sat, yd_out.pts.second_start_y);
      o1_b2 <= ux2 ? diff33(yd_out.x, yd_out.pts.second_end_x)
                   : diff33(y_sat, yd_out.pts.second_end_y);

      o2_side <= o1_side;
      o2_p1   <= o1_a1 * o1_b1;
      o2_p2   <= o1_a2 * o1_b2;
    end
  end

  // Z follows the first segment only when the point lies on it alone.
  assign on_lim = signed'({34'd0, on_tol});
  assign on1    = o2_p1 <= on_lim;
  assign on2    = o2_p2 <= on_lim;
  assign zs1    = on1 && !on2;

  always_comb begin
    if (zs1) begin
      zsx = o2_side.pts.first_start_x;
      zsy = o2_side.pts.first_start_y;
      zsz = o2_side.pts.first_start_z;
      zex = o2_side.pts.first_end_x;
      zey = o2_side.pts.first_end_y;
      zez = o2_side.pts.first_end_z;
    end else begin
      zsx = o2_side.pts.second_start_x;
      zsy = o2_side.pts.second_start_y;
      zsz = o2_side.pts.second_start_z;
      zex = o2_side.pts.second_end_x;
      zey = o2_side.pts.second_end_y;
      zez = o2_side.pts.second_end_z;
    end
  end

  assign zdx = diff33(zex, zsx);
  assign zdy = diff33(zey, zsy);
  assign uy  = mag33(zdx) < mag33(zdy);

  always_ff @(posedge clk) begin
    if (en) begin
      o3_side.parallel <= o2_side.parallel;
      o3_side.cls      <= CLASS_NEITHER + {1'b0, on2, 1'b0} + {2'b00, on1};
      o3_side.x        <= o2_side.x;
      o3_side.y        <= o2_side.y;
      o3_side.sz       <= zsz;
      o3_dz            <= diff33(zez, zsz);
      o3_f             <= uy ? diff33(o2_side.y, zsy) : diff33(o2_side.x, zsx);
      o3_den           <= uy ? zdy : zdx;

      o4_side <= o3_side;
      o4_prod <= o3_dz * o3_f;
      o4_den  <= o3_den;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      y1_valid <= 1'b0;
      y2_valid <= 1'b0;
      o1_valid <= 1'b0;
      o2_valid <= 1'b0;
      o3_valid <= 1'b0;
      o4_valid <= 1'b0;
    end else if (en) begin
      y1_valid <= xd_valid;
      y2_valid <= y1_valid;
      o1_valid <= yd_valid;
      o2_valid <= o1_valid;
      o3_valid <= o2_valid;
      o4_valid <= o3_valid;
    end
  end

  sic_div #(.NW(66), .DW(33), .PW($bits(zside_t))) u_div_z (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (o4_valid),
    .num       (o4_prod),
    .den       (o4_den),
    .side_in   (o4_side),
    .out_valid (zd_valid),
    .quo       (zd_quo),
    .side_out  (zd_out)
  );

  assign z_sat = sat32(36'(zd_quo) + 36'(zd_out.sz));

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= zd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zd_out.parallel) begin
        result <= '{hit_class: CLASS_PARALLEL, cross_x: '0, cross_y: '0, cross_z: '0};
      end else begin
        result <= '{hit_class: zd_out.cls, cross_x: zd_out.x, cross_y: zd_out.y,
                    cross_z: z_sat};
      end
    end
  end

endmodule

@@ sv/sic_div.sv @@
// ----------------------------------------------------------------------------
// sic_div
// Pipelined restoring divider, one quotient bit per stage. Quotients whose
// magnitude reaches 2^33 are flagged and returned as plus or minus 2^33.
// ----------------------------------------------------------------------------
module sic_div #(
  parameter int NW = 66,
  parameter int DW = 33,
  parameter int PW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  input  logic [PW-1:0]        side_in,
  output logic                 out_valid,
  output sic_pkg::quo_t        quo,
  output logic [PW-1:0]        side_out
);
  import sic_pkg::*;

  localparam int CW = (NW > DW + QB) ? NW : DW + QB;

  logic          vld   [0:QB];
  logic [CW-1:0] rem   [0:QB-1];
  logic [DW-1:0] dmag  [0:QB-1];
  logic [QB-1:0] qbits [0:QB];
  logic          neg   [0:QB];
  logic          ovf   [0:QB];
  logic [PW-1:0] side  [0:QB];

  logic [NW-1:0] num_mag;
  logic [DW-1:0] den_mag;
  logic signed [QW-1:0] mag_s;

  assign num_mag = num[NW-1] ? NW'(-num) : NW'(num);
  assign den_mag = den[DW-1] ? DW'(-den) : DW'(den);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      rem[0]   <= CW'(num_mag);
      dmag[0]  <= den_mag;
      qbits[0] <= '0;
      neg[0]   <= num[NW-1] ^ den[DW-1];
      ovf[0]   <= CW'(num_mag) >= (CW'(den_mag) << QB);
      side[0]  <= side_in;
    end
  end

  for (genvar g = 1; g <= QB; g++) begin : g_stage
    localparam int K = QB - g;
    logic [CW-1:0] trial;
    logic          take;

    assign trial = CW'(dmag[g-1]) << K;
    assign take  = rem[g-1] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= vld[g-1];
      end
      if (en) begin
        qbits[g] <= qbits[g-1] | (QB'(take) << K);
        neg[g]   <= neg[g-1];
        ovf[g]   <= ovf[g-1];
        side[g]  <= side[g-1];
      end
    end

    if (g < QB) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem[g]  <= take ? rem[g-1] - trial : rem[g-1];
          dmag[g] <= dmag[g-1];
        end
      end
    end
  end

  assign mag_s = signed'(QW'(qbits[QB]));

  always_comb begin
    if (ovf[QB]) begin
      quo = neg[QB] ? -QUO_LIMIT : QUO_LIMIT;
    end else begin
      quo = neg[QB] ? -mag_s : mag_s;
    end
  end

  assign out_valid = vld[QB];
  assign side_out  = side[QB];

endmodule

@@ sv/sic_front.sv @@
// ----------------------------------------------------------------------------
// sic_front
// Line setup: direction vectors, cross product, the X numerator in partial
// products, and the parallel test against the tolerance.
// ----------------------------------------------------------------------------
module sic_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  sic_pkg::sic_in_t               request,
  input  logic [31:0]                    parallel_tol,
  output logic                           out_valid,
  output logic signed [sic_pkg::NUM_W-1:0] num,
  output logic signed [sic_pkg::FD_W-1:0]  den,
  output logic                           parallel,
  output sic_pkg::sic_in_t               side
);
  import sic_pkg::*;

  logic               v0, v1, v2;
  sic_in_t            d0, d1, d2;
  logic signed [32:0] dx1, dy1, dx2, dy2, dys;
  logic signed [32:0] dys1;
  logic signed [65:0] fd1, fd2, mm;
  logic signed [66:0] fd3;
  logic signed [65:0] pl1, pl2;
  logic signed [64:0] ph1, ph2;
  logic signed [66:0] pl3;
  logic signed [65:0] ph3;
  logic [66:0]        a3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0        <= in_valid;
      v1        <= v0;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0  <= request;
      dx1 <= 33'(request.first_end_x) - 33'(request.first_start_x);
      dy1 <= 33'(request.first_end_y) - 33'(request.first_start_y);
      dx2 <= 33'(request.second_end_x) - 33'(request.second_start_x);
      dy2 <= 33'(request.second_end_y) - 33'(request.second_start_y);
      dys <= 33'(request.second_start_y) - 33'(request.first_start_y);

      d1   <= d0;
      fd1  <= dx1 * dy2;
      fd2  <= dx2 * dy1;
      mm   <= dx1 * dx2;
      dys1 <= dys;

      d2  <= d1;
      fd3 <= 67'(fd1) - 67'(fd2);
      pl1 <= signed'({1'b0, fd1[32:0]}) * d1.second_start_x;
      ph1 <= signed'(fd1[65:33]) * d1.second_start_x;
      pl2 <= signed'({1'b0, fd2[32:0]}) * d1.first_start_x;
      ph2 <= signed'(fd2[65:33]) * d1.first_start_x;
      pl3 <= signed'({1'b0, mm[32:0]}) * dys1;
      ph3 <= signed'(mm[65:33]) * dys1;

      side     <= d2;
      den      <= fd3;
      num      <= (NUM_W'(ph1) <<< 33) + NUM_W'(pl1)
                - (NUM_W'(ph2) <<< 33) - NUM_W'(pl2)
                - (NUM_W'(ph3) <<< 33) - NUM_W'(pl3);
      parallel <= (a3 == '0) || (a3 < 67'(parallel_tol));
    end
  end

  assign a3 = fd3[66] ? 67'(-fd3) : 67'(fd3);

endmodule
